// ----- rtl/core/kart_pkg.sv -----
// Package: item types, field widths and mode / register codes for the autorepeat timer.
`timescale 1ns / 1ps
package kart_pkg;

    localparam int ACC_W     = 64;  // accumulator width
    localparam int DIV_W     = 32;  // divisor / remainder width
    localparam int DIGIT_W   = 16;  // adder digit width
    localparam int SYM_W     = 29;
    localparam int CODE_W    = 21;
    localparam int ELAPSED_W = 32;
    localparam int CNT_W     = 16;
    localparam int PERIOD_W  = 30;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // item modes
    localparam logic [1:0] MODE_KEY     = 2'd0;
    localparam logic [1:0] MODE_FOCUS   = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_DISPLAY = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_COUNT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 8'd3;

    // register reset values
    localparam logic [DIV_W-1:0]    RST_BLINK_INTERVAL = 32'd500000000;
    localparam logic [CNT_W-1:0]    RST_BLINK_COUNT    = 16'd10;
    localparam logic [DIV_W-1:0]    RST_REPEAT_DELAY   = 32'd500000000;
    localparam logic [PERIOD_W-1:0] RST_REPEAT_PERIOD  = 30'd25000000;

    typedef struct packed {
        logic [1:0]           mode;
        logic [SYM_W-1:0]     key_sym;
        logic [CODE_W-1:0]    key_code;
        logic                 pressed;
        logic [ELAPSED_W-1:0] elapsed_ns;
    } t_in_item;

    typedef struct packed {
        logic              cursor_shown;
        logic              cursor_changed;
        logic              repeat_fire;
        logic [SYM_W-1:0]  repeat_sym;
        logic [CODE_W-1:0] repeat_code;
    } t_out_item;

endpackage

// ----- rtl/core/kart_digit_add.sv -----
// Digit-serial saturating adder: 64-bit accumulator plus 32-bit elapsed time.
`timescale 1ns / 1ps
module kart_digit_add
    import kart_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ACC_W-1:0]     i_acc,
    input  logic [ELAPSED_W-1:0] i_add,
    output logic                 o_done,
    output logic [ACC_W-1:0]     o_sum
);

    localparam int STEPS  = ACC_W / DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [ACC_W-1:0]   r_a;
    logic [ACC_W-1:0]   r_b;
    logic [ACC_W-1:0]   r_sum;
    logic               r_carry;
    logic [DIGIT_W:0]   w_digit;
    logic               w_last;

    assign w_digit = {1'b0, r_a[DIGIT_W-1:0]} + {1'b0, r_b[DIGIT_W-1:0]}
                   + {{DIGIT_W{1'b0}}, r_carry};
    assign w_last  = (r_cnt == STEP_W'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_a     <= i_acc;
                r_b     <= {{(ACC_W-ELAPSED_W){1'b0}}, i_add};
                r_carry <= 1'b0;
            end else if (r_busy) begin
                // LSB digit first, sum fills from the top
                r_a     <= r_a >> DIGIT_W;
                r_b     <= r_b >> DIGIT_W;
                r_sum   <= {w_digit[DIGIT_W-1:0], r_sum[ACC_W-1:DIGIT_W]};
                r_carry <= w_digit[DIGIT_W];
                r_cnt   <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_carry ? {ACC_W{1'b1}} : r_sum;

endmodule

// ----- rtl/core/kart_serial_rem.sv -----
// Bit-serial restoring remainder: 64-bit dividend modulo 32-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module kart_serial_rem
    import kart_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem,
    output logic             o_hit     // quotient nonzero, i.e. dividend >= divisor
);

    localparam int CNT_BITS = $clog2(ACC_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [ACC_W-1:0]    r_num;
    logic [DIV_W-1:0]    r_den;
    logic [DIV_W-1:0]    r_rem;
    logic                r_hit;
    logic [DIV_W:0]      w_trial;
    logic [DIV_W:0]      w_diff;
    logic                w_ge;
    logic                w_last;

    assign w_trial = {r_rem, r_num[ACC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_last  = (r_cnt == CNT_BITS'(ACC_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_hit  <= 1'b0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_hit <= r_hit | w_ge;
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_hit  = r_hit;

endmodule

// ----- rtl/core/key_autorepeat_cursor_blink_timer_core.sv -----
// Top level: key autorepeat and cursor blink timer with digit-serial accumulator update.
//
//  channel | signals                                  | direction | item
//  --------+------------------------------------------+-----------+---------------------------
//  in      | i_in_valid  / o_in_ready  / i_in_data    | sink      | key, focus, tick, display
//  out     | o_out_valid / i_out_ready / o_out_data   | source    | one result per item
//  cfg     | i_cfg_valid / o_cfg_ready / i_cfg_index, | sink      | register write
//          | i_cfg_data                               |           |
//
// Key, focus-leave and display items go from accept straight to S_DONE. A tick first runs
// 16-bit digit adds for both accumulators (S_ADD), then hands off to the bit-serial
// remainder units (S_REM, one dividend bit per cycle) and waits to see both done. In S_DONE
// the result is registered once the output register is free.
// One item is in flight at a time; the next is accepted once its result is registered.
// A result waiting on a stalled output blocks only the completion of the next item.
// Synchronous active-low reset; no clearing pass. Config writes are always accepted.
`timescale 1ns / 1ps
module key_autorepeat_cursor_blink_timer_core
    import kart_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_DONE
    } t_state;

    // config registers
    logic [DIV_W-1:0]    r_blink_interval;
    logic [CNT_W-1:0]    r_blink_reload;
    logic [DIV_W-1:0]    r_repeat_delay;
    logic [PERIOD_W-1:0] r_repeat_period;

    // control / timer state
    t_state              r_state,        n_state;
    t_in_item            r_item,         n_item;
    logic [SYM_W-1:0]    r_held_sym,     n_held_sym;
    logic [CODE_W-1:0]   r_held_code,    n_held_code;
    logic [ACC_W-1:0]    r_repeat_accum, n_repeat_accum;
    logic                r_repeating,    n_repeating;
    logic [ACC_W-1:0]    r_blink_accum,  n_blink_accum;
    logic [CNT_W-1:0]    r_blinks_left,  n_blinks_left;
    logic                r_visible,      n_visible;
    logic                r_out_valid,    n_out_valid;
    t_out_item           r_out,          n_out;

    logic                w_in_acc;
    logic                w_add_start;
    logic                w_rem_start;
    logic                w_out_free;

    logic                w_badd_done, w_radd_done;
    logic [ACC_W-1:0]    w_bsum, w_rsum;
    logic                w_brem_done, w_rrem_done;
    logic [DIV_W-1:0]    w_brem, w_rrem;
    logic                w_bhit, w_rhit;
    logic [DIV_W-1:0]    w_thr_raw, w_thr;
    logic                w_blink_do, w_fire;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_add_start = w_in_acc && (i_in_data.mode == MODE_TICK);
    assign w_rem_start = (r_state == S_ADD) && w_badd_done && w_radd_done;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // repeat threshold: first delay, then period; zero acts as one
    assign w_thr_raw = r_repeating ? {{(DIV_W-PERIOD_W){1'b0}}, r_repeat_period}
                                   : r_repeat_delay;
    assign w_thr     = (w_thr_raw == '0) ? DIV_W'(1) : w_thr_raw;

    kart_digit_add u_blink_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_add_start),
        .i_acc   (r_blink_accum),
        .i_add   (i_in_data.elapsed_ns),
        .o_done  (w_badd_done),
        .o_sum   (w_bsum)
    );

    kart_digit_add u_repeat_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_add_start),
        .i_acc   (r_repeat_accum),
        .i_add   (i_in_data.elapsed_ns),
        .o_done  (w_radd_done),
        .o_sum   (w_rsum)
    );

    // divisor 0 (blink off) runs harmlessly; its result is discarded below
    kart_serial_rem u_blink_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_bsum),
        .i_divisor  (r_blink_interval),
        .o_done     (w_brem_done),
        .o_rem      (w_brem),
        .o_hit      (w_bhit)
    );

    kart_serial_rem u_repeat_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_rsum),
        .i_divisor  (w_thr),
        .o_done     (w_rrem_done),
        .o_rem      (w_rrem),
        .o_hit      (w_rhit)
    );

    // hit means sum >= divisor, so no separate wide compare
    assign w_blink_do = (r_blink_interval != '0) && (r_blinks_left != '0) && w_bhit;
    assign w_fire     = (r_held_sym != '0) && w_rhit;

    always_comb begin
        n_state        = r_state;
        n_item         = r_item;
        n_held_sym     = r_held_sym;
        n_held_code    = r_held_code;
        n_repeat_accum = r_repeat_accum;
        n_repeating    = r_repeating;
        n_blink_accum  = r_blink_accum;
        n_blinks_left  = r_blinks_left;
        n_visible      = r_visible;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item  = i_in_data;
                    n_state = (i_in_data.mode == MODE_TICK) ? S_ADD : S_DONE;
                end
            end
            S_ADD: begin
                if (w_rem_start) begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                if (w_brem_done && w_rrem_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    case (r_item.mode)
                        MODE_KEY: begin
                            if (r_item.pressed) begin
                                n_held_sym     = r_item.key_sym;
                                n_held_code    = r_item.key_code;
                                n_repeat_accum = '0;
                                n_repeating    = 1'b0;
                            end else if (r_item.key_sym == r_held_sym) begin
                                n_held_sym = '0;
                            end
                        end
                        MODE_FOCUS: begin
                            n_held_sym = '0;
                        end
                        MODE_DISPLAY: begin
                            n_blink_accum         = '0;
                            n_visible             = 1'b1;
                            n_blinks_left         = r_blink_reload;
                            n_out.cursor_changed  = 1'b1;
                        end
                        default: begin
                            // tick: blink step, then repeat step
                            n_blink_accum  = w_bsum;
                            n_repeat_accum = w_rsum;
                            if (w_blink_do) begin
                                n_blink_accum        = {{(ACC_W-DIV_W){1'b0}}, w_brem};
                                n_visible            = !r_visible;
                                n_blinks_left        = r_blinks_left - 1'b1;
                                n_out.cursor_changed = 1'b1;
                            end
                            if (w_fire) begin
                                n_repeat_accum    = {{(ACC_W-DIV_W){1'b0}}, w_rrem};
                                n_repeating       = 1'b1;
                                n_out.repeat_fire = 1'b1;
                                n_out.repeat_sym  = r_held_sym;
                                n_out.repeat_code = r_held_code;
                            end
                        end
                    endcase
                    n_out.cursor_shown = n_visible;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_held_sym       <= '0;
            r_held_code      <= '0;
            r_repeat_accum   <= '0;
            r_repeating      <= 1'b0;
            r_blink_accum    <= '0;
            r_blinks_left    <= RST_BLINK_COUNT;
            r_visible        <= 1'b1;
            r_out_valid      <= 1'b0;
            r_blink_interval <= RST_BLINK_INTERVAL;
            r_blink_reload   <= RST_BLINK_COUNT;
            r_repeat_delay   <= RST_REPEAT_DELAY;
            r_repeat_period  <= RST_REPEAT_PERIOD;
        end else begin
            r_state        <= n_state;
            r_held_sym     <= n_held_sym;
            r_held_code    <= n_held_code;
            r_repeat_accum <= n_repeat_accum;
            r_repeating    <= n_repeating;
            r_blink_accum  <= n_blink_accum;
            r_blinks_left  <= n_blinks_left;
            r_visible      <= n_visible;
            r_out_valid    <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BLINK_INTERVAL: r_blink_interval <= i_cfg_data;
                    REG_BLINK_COUNT:    r_blink_reload   <= i_cfg_data[CNT_W-1:0];
                    REG_REPEAT_DELAY:   r_repeat_delay   <= i_cfg_data;
                    REG_REPEAT_PERIOD:  r_repeat_period  <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the key autorepeat and cursor blink timer core.
`timescale 1ns / 1ps
module tb;
    import kart_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned IDLE_PCT    = 21;
    localparam int unsigned CALM_FROM   = 450;   // accepted-item window with no idling
    localparam int unsigned CALM_TO     = 700;
    localparam int unsigned TICK_LAT    = 80;    // margin for a tick to finish

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hA5;  // not decoded by the block

    localparam logic [SYM_W-1:0]     SYM_MAX     = '1;
    localparam logic [CODE_W-1:0]    CODE_MAX    = 21'd1114111;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    key_autorepeat_cursor_blink_timer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow registers
    logic [DIV_W-1:0]    blink_half_ns;
    logic [CNT_W-1:0]    toggle_reload;
    logic [DIV_W-1:0]    first_delay_ns;
    logic [PERIOD_W-1:0] rpt_period_ns;

    // Shadow timer state
    logic [SYM_W-1:0]  hold_sym;
    logic [CODE_W-1:0] hold_code;
    logic [ACC_W-1:0]  rpt_sum;
    logic              in_period;     // first delay already passed
    logic [ACC_W-1:0]  blink_sum;
    logic [CNT_W-1:0]  toggles_left;
    logic              cursor_on;

    t_in_item  queued_events[$];
    t_out_item expected_reports[$];

    int unsigned queued_cnt;
    int unsigned accepted_cnt;
    int unsigned checked_cnt;
    int unsigned fired_cnt;
    int unsigned cursor_cnt;
    int unsigned mismatches;
    int unsigned cycle_cnt;
    logic        in_hit;               // input item taken at the last rising edge

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc,
                                                 logic [ELAPSED_W-1:0] inc);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {{(ACC_W-ELAPSED_W+1){1'b0}}, inc};
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

    // Advance the shadow timer by one item and return the result it must produce.
    function automatic t_out_item advance_timer(t_in_item it);
        t_out_item        res;
        logic [ACC_W-1:0] thr;
        res = '0;
        case (it.mode)
            MODE_KEY: begin
                if (it.pressed) begin
                    hold_sym  = it.key_sym;
                    hold_code = it.key_code;
                    rpt_sum   = '0;
                    in_period = 1'b0;
                end else if (it.key_sym == hold_sym) begin
                    hold_sym = '0;   // code is kept on purpose
                end
            end
            MODE_FOCUS: hold_sym = '0;
            MODE_DISPLAY: begin
                blink_sum    = '0;
                cursor_on    = 1'b1;
                toggles_left = toggle_reload;
                res.cursor_changed = 1'b1;
            end
            MODE_TICK: begin
                blink_sum = sat_add(blink_sum, it.elapsed_ns);
                rpt_sum   = sat_add(rpt_sum, it.elapsed_ns);
                // blink first, at most one toggle; zero interval means off
                if (blink_half_ns != 0 && toggles_left != 0 &&
                    blink_sum >= {32'b0, blink_half_ns}) begin
                    blink_sum    = blink_sum % {32'b0, blink_half_ns};
                    cursor_on    = ~cursor_on;
                    toggles_left = toggles_left - 1'b1;
                    res.cursor_changed = 1'b1;
                end
                thr = in_period ? {34'b0, rpt_period_ns} : {32'b0, first_delay_ns};
                if (thr == 0)
                    thr = 64'd1;
                if (hold_sym != 0 && rpt_sum >= thr) begin
                    rpt_sum   = rpt_sum % thr;
                    in_period = 1'b1;
                    res.repeat_fire = 1'b1;
                    res.repeat_sym  = hold_sym;
                    res.repeat_code = hold_code;
                end
            end
        endcase
        res.cursor_shown = cursor_on;
        return res;
    endfunction

    task automatic flag_field(input string field, input longint unsigned want_v,
                              input longint unsigned got_v);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, want_v, got_v);
        mismatches++;
    endtask

    // Monitor: checks results, tracks register writes, predicts accepted items.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            blink_half_ns  = RST_BLINK_INTERVAL;
            toggle_reload  = RST_BLINK_COUNT;
            first_delay_ns = RST_REPEAT_DELAY;
            rpt_period_ns  = RST_REPEAT_PERIOD;
            hold_sym       = '0;
            hold_code      = '0;
            rpt_sum        = '0;
            in_period      = 1'b0;
            blink_sum      = '0;
            toggles_left   = RST_BLINK_COUNT;
            cursor_on      = 1'b1;
            in_hit         = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: result with none expected, got %p", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (o_out_data.cursor_shown !== want.cursor_shown)
                        flag_field("cursor_shown", 64'(want.cursor_shown),
                                   64'(o_out_data.cursor_shown));
                    if (o_out_data.cursor_changed !== want.cursor_changed)
                        flag_field("cursor_changed", 64'(want.cursor_changed),
                                   64'(o_out_data.cursor_changed));
                    if (o_out_data.repeat_fire !== want.repeat_fire)
                        flag_field("repeat_fire", 64'(want.repeat_fire),
                                   64'(o_out_data.repeat_fire));
                    if (o_out_data.repeat_sym !== want.repeat_sym)
                        flag_field("repeat_sym", 64'(want.repeat_sym),
                                   64'(o_out_data.repeat_sym));
                    if (o_out_data.repeat_code !== want.repeat_code)
                        flag_field("repeat_code", 64'(want.repeat_code),
                                   64'(o_out_data.repeat_code));
                    checked_cnt++;
                    fired_cnt  += 32'(want.repeat_fire);
                    cursor_cnt += 32'(want.cursor_changed);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BLINK_INTERVAL: blink_half_ns  = i_cfg_data;
                    REG_BLINK_COUNT:    toggle_reload  = i_cfg_data[CNT_W-1:0];
                    REG_REPEAT_DELAY:   first_delay_ns = i_cfg_data;
                    REG_REPEAT_PERIOD:  rpt_period_ns  = i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                expected_reports.push_back(advance_timer(i_in_data));
                accepted_cnt++;
            end
            in_hit = i_in_valid && o_in_ready;
        end
    end

    // Driver: feeds queued items and randomizes output backpressure.
    always @(negedge i_clk) begin : drive
        logic     nxt_valid;
        t_in_item nxt_data;
        logic     calm;
        calm      = accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (i_in_valid && in_hit)
            nxt_valid = 1'b0;
        if (!nxt_valid && queued_events.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt_data  = queued_events.pop_front();
            nxt_valid = 1'b1;
        end
        i_in_valid  <= nxt_valid;
        i_in_data   <= nxt_data;
        i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic post_item(input logic [1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic pressed,
                             input logic [ELAPSED_W-1:0] elapsed);
        t_in_item it;
        it.mode       = mode;
        it.key_sym    = sym;
        it.key_code   = code;
        it.pressed    = pressed;
        it.elapsed_ns = elapsed;
        queued_events.push_back(it);
        queued_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready))
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_timer_regs(input logic [31:0] blink, input logic [31:0] count,
                                   input logic [31:0] delay, input logic [31:0] period);
        write_reg(REG_BLINK_INTERVAL, blink);
        write_reg(REG_BLINK_COUNT, count);
        write_reg(REG_REPEAT_DELAY, delay);
        write_reg(REG_REPEAT_PERIOD, period);
    endtask

    // Wait for every item to be taken and answered, then let a tick's worth pass.
    task automatic settle();
        while (accepted_cnt != queued_cnt || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (TICK_LAT) @(negedge i_clk);
    endtask

    // Mostly press / tick / release traffic on a small key set, some junk mixed in.
    task automatic random_run(input int n, input int unsigned lo, input int unsigned hi);
        logic [SYM_W-1:0]     keys [4];
        logic [ELAPSED_W-1:0] el;
        int unsigned          r;
        int unsigned          sel;
        for (int k = 0; k < 4; k++)
            keys[k] = SYM_W'($urandom_range(1, 32'h1FFF_FFFF));
        if ($urandom_range(0, 1))
            keys[3] = SYM_MAX;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
                el = $urandom();
            else if (sel < 6)
                el = '0;
            else
                el = $urandom_range(lo, hi);
            r = $urandom_range(0, 99);
            if (r < 8)
                post_item(MODE_KEY, keys[$urandom_range(0, 3)],
                          CODE_W'($urandom_range(0, CODE_MAX)), 1'b1, $urandom());
            else if (r < 13)
                post_item(MODE_KEY, keys[$urandom_range(0, 3)],
                          CODE_W'($urandom_range(0, CODE_MAX)), 1'b0, $urandom());
            else if (r < 15)
                post_item(MODE_FOCUS, SYM_W'($urandom()), CODE_W'($urandom_range(0, CODE_MAX)),
                          1'($urandom_range(0, 1)), $urandom());
            else if (r < 18)
                post_item(MODE_DISPLAY, SYM_W'($urandom()),
                          CODE_W'($urandom_range(0, CODE_MAX)),
                          1'($urandom_range(0, 1)), $urandom());
            else if (r < 92)
                post_item(MODE_TICK, SYM_W'($urandom()), CODE_W'($urandom_range(0, CODE_MAX)),
                          1'($urandom_range(0, 1)), el);
            else
                post_item(2'($urandom_range(0, 3)), SYM_W'($urandom()),
                          CODE_W'($urandom_range(0, CODE_MAX)),
                          1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        queued_cnt   = 0;
        accepted_cnt = 0;
        checked_cnt  = 0;
        fired_cnt    = 0;
        cursor_cnt   = 0;
        mismatches   = 0;
        cycle_cnt    = 0;
        in_hit       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass on the reset register values
        post_item(MODE_TICK, '0, '0, 1'b0, '0);                   // empty tick
        post_item(MODE_DISPLAY, SYM_MAX, CODE_MAX, 1'b1, ELAPSED_MAX);
        post_item(MODE_FOCUS, '0, '0, 1'b0, '0);
        post_item(MODE_KEY, SYM_MAX, CODE_MAX, 1'b1, '0);         // widest key held
        post_item(MODE_TICK, '0, '0, 1'b0, 32'd499999999);        // one short of both
        post_item(MODE_TICK, '0, '0, 1'b0, 32'd1);                // exactly at both
        post_item(MODE_TICK, '0, '0, 1'b0, 32'd24999999);         // one short of period
        post_item(MODE_TICK, '0, '0, 1'b0, 32'd1);                // period reached
        post_item(MODE_KEY, 29'h123, '0, 1'b0, '0);               // other key released
        post_item(MODE_TICK, SYM_MAX, CODE_MAX, 1'b1, ELAPSED_MAX); // one toggle, one repeat
        post_item(MODE_KEY, SYM_MAX, '0, 1'b0, '0);               // held key released
        post_item(MODE_TICK, '0, '0, 1'b0, ELAPSED_MAX);
        post_item(MODE_KEY, '0, 21'd5, 1'b1, '0);                 // press without a symbol
        post_item(MODE_TICK, '0, '0, 1'b0, ELAPSED_MAX);
        post_item(MODE_KEY, 29'd1, CODE_MAX, 1'b1, '0);
        post_item(MODE_FOCUS, '0, '0, 1'b0, '0);                  // focus leave drops it
        post_item(MODE_TICK, '0, '0, 1'b0, ELAPSED_MAX);
        post_item(MODE_KEY, '0, '0, 1'b0, '0);                    // release with nothing held
        for (int i = 0; i < 6; i++)                               // run out of toggles
            post_item(MODE_TICK, '0, '0, 1'b0, ELAPSED_MAX);
        post_item(MODE_DISPLAY, '0, '0, 1'b0, '0);                // reload toggles
        settle();

        // Fast timers, large toggle budget, plus a write to an undecoded index
        load_timer_regs(32'd1000, 32'd65535, 32'd3000, 32'd700);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        random_run(220, 0, 2000);
        settle();

        // Largest values; upper data bits must be dropped for the narrow registers
        load_timer_regs(32'hFFFF_FFFF, 32'hABCD_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_run(150, 32'h8000_0000, 32'hFFFF_FFFF);
        settle();

        // Blink off, zero repeat thresholds behave as one
        load_timer_regs(32'd0, 32'd3, 32'd0, 32'd0);
        random_run(150, 0, 50);
        settle();

        // Default rates with 60 Hz ticks
        load_timer_regs(RST_BLINK_INTERVAL, 32'(RST_BLINK_COUNT), RST_REPEAT_DELAY,
                        32'(RST_REPEAT_PERIOD));
        random_run(250, 32'd16000000, 32'd17400000);
        settle();

        for (int p = 0; p < 3; p++) begin
            load_timer_regs($urandom_range(0, 3000), $urandom_range(0, 12),
                            $urandom_range(0, 5000), $urandom_range(0, 1500));
            random_run(110, 0, 2500);
            settle();
        end

        $display("Checked %0d results for %0d items in %0d cycles.",
                 checked_cnt, accepted_cnt, cycle_cnt);
        $display("Repeats fired: %0d, cursor updates: %0d, mismatches: %0d.",
                 fired_cnt, cursor_cnt, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
